>>> rtl/swbm_pkg.sv
package swbm_pkg;

    // Timer width of every configured time and of the tick counter
    localparam int TIMER_BITS = 10;
    // One more than the number of two-tick checks for a released line before reset gives up
    localparam int HIGH_WAIT_LIMIT = 125;

    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [TIMER_BITS-1:0] t_tick;
    typedef logic [TIMER_BITS:0]   t_tick_ext;

    localparam logic [7:0] WAIT_INIT = 8'(HIGH_WAIT_LIMIT - 1);

    // Fixed reset-sequence phase lengths in ticks
    localparam t_tick LEN_RWAIT   = t_tick'(2);
    localparam t_tick LEN_RHIGH   = t_tick'(200);
    localparam t_tick LEN_RFLOAT  = t_tick'(20);
    localparam t_tick LEN_RPULSE  = t_tick'(1);
    localparam t_tick LEN_RSAMPLE = t_tick'(2);
    localparam t_tick LEN_RTAIL   = t_tick'(21);

    // Command kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_RESET = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_START = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_ZERO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_BIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_BIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH  = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RWAIT,
        PH_RHIGH,
        PH_RLOW,
        PH_RFLOAT,
        PH_RPULSE,
        PH_RSAMPLE,
        PH_RTAIL,
        PH_WBITS,
        PH_WACK,
        PH_RBITS,
        PH_RACK,
        PH_START
    } t_phase;

    // One decoded tick as it waits in the queue
    typedef struct packed {
        logic       cmd;
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       master_nack;
        logic       line_level;
    } t_item;

    // Queue head handed to the bus engine
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // A time of zero counts as one tick
    function automatic t_tick lim_time(input t_tick v);
        return (v == '0) ? t_tick'(1) : v;
    endfunction

endpackage

>>> rtl/swbm_front.sv
module swbm_front
    import swbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: data_byte[7:0], master_nack[8], line_level[9], zero pad[15:10]
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [IN_TUSER_W-1:0] s_axis_tuser,
    output t_head                 o_head,
    input  logic                  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    t_item              w_item;
    logic               w_push;
    logic               w_pop;

    // Classify the incoming tick
    always_comb begin
        w_item.cmd         = s_axis_tuser inside {[KIND_RESET:KIND_START]};
        w_item.kind        = s_axis_tuser;
        w_item.data_byte   = s_axis_tdata[7:0];
        w_item.master_nack = s_axis_tdata[8];
        w_item.line_level  = s_axis_tdata[9];
    end

    assign s_axis_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_pop && (r_count != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

>>> rtl/swbm_engine.sv
module swbm_engine
    import swbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  t_tick                  i_cfg_wdata,
    input  t_head                  i_head,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Configuration registers
    t_tick r_low_one, r_low_zero, r_wr_bit, r_rd_low;
    t_tick r_rd_sample, r_rd_bit, r_rst_low, r_start_high;
    t_tick r_sample_idx;

    // Bus state
    t_phase     r_phase, n_phase;
    t_tick      r_tick, n_tick;
    logic [3:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_nack, n_nack;
    logic [7:0] r_wait, n_wait;
    logic       r_ack, n_ack;
    logic       r_presence, n_presence;
    logic [7:0] r_held, n_held;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // State after command start
    logic       w_start;
    t_phase     w_phase;
    t_tick      w_tick;
    logic [3:0] w_bit;
    logic [7:0] w_shift;
    logic       w_nack;
    logic [7:0] w_wait;
    logic       w_presence;
    t_tick      w_len;
    t_tick_ext  w_tick_inc;
    logic       w_last;
    logic       w_sample;
    t_tick      w_low;
    logic       w_fire;
    logic       w_line;

    logic       w_drive, w_busy, w_done, w_rej;
    t_tick_ext  w_s_sum;
    t_tick_ext  w_s_last;

    assign w_fire = i_head.valid && (!r_out_valid || m_axis_tready);
    assign o_pop  = w_fire;
    assign w_line = i_head.item.line_level;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_one    <= t_tick'(1);
            r_low_zero   <= t_tick'(10);
            r_wr_bit     <= t_tick'(15);
            r_rd_low     <= t_tick'(1);
            r_rd_sample  <= t_tick'(1);
            r_rd_bit     <= t_tick'(11);
            r_rst_low    <= t_tick'(480);
            r_start_high <= t_tick'(150);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_ONE:    r_low_one    <= i_cfg_wdata;
                CFG_LOW_ZERO:   r_low_zero   <= i_cfg_wdata;
                CFG_WR_BIT:     r_wr_bit     <= i_cfg_wdata;
                CFG_RD_LOW:     r_rd_low     <= i_cfg_wdata;
                CFG_RD_SAMPLE:  r_rd_sample  <= i_cfg_wdata;
                CFG_RD_BIT:     r_rd_bit     <= i_cfg_wdata;
                CFG_RST_LOW:    r_rst_low    <= i_cfg_wdata;
                CFG_START_HIGH: r_start_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Read sample point, clamped to the last tick of the slot
    assign w_s_sum  = {1'b0, lim_time(r_rd_low)} + {1'b0, lim_time(r_rd_sample)} - 1'b1;
    assign w_s_last = {1'b0, lim_time(r_rd_bit)} - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_idx <= t_tick'(1);
        end else begin
            r_sample_idx <= (w_s_sum > w_s_last) ? w_s_last[TIMER_BITS-1:0]
                                                 : w_s_sum[TIMER_BITS-1:0];
        end
    end

    // Command start: a command is taken only in idle
    always_comb begin
        w_start    = i_head.item.cmd && (r_phase == PH_IDLE);
        w_phase    = r_phase;
        w_tick     = r_tick;
        w_bit      = r_bit;
        w_shift    = r_shift;
        w_nack     = r_nack;
        w_wait     = r_wait;
        w_presence = r_presence;
        if (w_start) begin
            w_tick = '0;
            w_bit  = '0;
            case (i_head.item.kind)
                KIND_RESET: begin
                    w_wait = WAIT_INIT;
                    if (WAIT_INIT == 8'd0) begin
                        w_presence = 1'b0;
                        w_phase    = PH_IDLE;
                    end else begin
                        w_phase = PH_RWAIT;
                    end
                end
                KIND_WRITE: begin
                    w_shift = i_head.item.data_byte;
                    w_phase = PH_WBITS;
                end
                KIND_READ: begin
                    w_shift = '0;
                    w_nack  = i_head.item.master_nack;
                    w_phase = PH_RBITS;
                end
                default: begin
                    w_phase = PH_START;
                end
            endcase
        end
    end

    // Slot length and low time of the current phase
    always_comb begin
        w_len = t_tick'(1);
        w_low = '0;
        case (w_phase)
            PH_RWAIT:   w_len = LEN_RWAIT;
            PH_RHIGH:   w_len = LEN_RHIGH;
            PH_RLOW:    w_len = lim_time(r_rst_low);
            PH_RFLOAT:  w_len = LEN_RFLOAT;
            PH_RPULSE:  w_len = LEN_RPULSE;
            PH_RSAMPLE: w_len = LEN_RSAMPLE;
            PH_RTAIL:   w_len = LEN_RTAIL;
            PH_WBITS: begin
                w_len = lim_time(r_wr_bit);
                w_low = lim_time(w_shift[7] ? r_low_one : r_low_zero);
            end
            PH_WACK, PH_RBITS: begin
                w_len = lim_time(r_rd_bit);
                w_low = lim_time(r_rd_low);
            end
            PH_RACK: begin
                w_len = lim_time(r_wr_bit);
                w_low = lim_time(w_nack ? r_low_one : r_low_zero);
            end
            PH_START:   w_len = lim_time(r_start_high);
            default: ;
        endcase
    end

    assign w_tick_inc = {1'b0, w_tick} + 1'b1;
    assign w_last     = (w_tick_inc >= {1'b0, w_len});
    assign w_sample   = (w_tick == r_sample_idx);

    // Next state
    always_comb begin
        n_phase    = w_phase;
        n_tick     = w_last ? '0 : w_tick_inc[TIMER_BITS-1:0];
        n_bit      = w_bit;
        n_shift    = w_shift;
        n_nack     = w_nack;
        n_wait     = w_wait;
        n_ack      = r_ack;
        n_presence = w_presence;
        n_held     = r_held;
        case (w_phase)
            PH_RWAIT: begin
                if (w_last) begin
                    if (w_line) begin
                        n_phase = PH_RHIGH;
                    end else begin
                        n_wait = w_wait - 1'b1;
                        if (n_wait == 8'd0) begin
                            n_presence = 1'b0;
                            n_phase    = PH_IDLE;
                            n_bit      = '0;
                        end
                    end
                end
            end
            PH_RHIGH:  if (w_last) n_phase = PH_RLOW;
            PH_RLOW:   if (w_last) n_phase = PH_RFLOAT;
            PH_RFLOAT: if (w_last) n_phase = PH_RPULSE;
            PH_RPULSE: if (w_last) n_phase = PH_RSAMPLE;
            PH_RSAMPLE: begin
                if (w_last) begin
                    n_presence = !w_line;
                    n_phase    = PH_RTAIL;
                end
            end
            PH_RTAIL: begin
                if (w_last) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                end
            end
            PH_WBITS: begin
                if (w_last) begin
                    n_shift = {w_shift[6:0], 1'b0};
                    n_bit   = w_bit + 1'b1;
                    if (n_bit >= 4'd8) begin
                        n_bit   = '0;
                        n_phase = PH_WACK;
                    end
                end
            end
            PH_WACK: begin
                if (w_sample) n_ack = !w_line;
                if (w_last) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                end
            end
            PH_RBITS: begin
                if (w_sample) n_shift = {w_shift[6:0], w_line};
                if (w_last) begin
                    n_bit = w_bit + 1'b1;
                    if (n_bit >= 4'd8) begin
                        n_bit   = '0;
                        n_held  = n_shift;
                        n_phase = PH_RACK;
                    end
                end
            end
            PH_RACK, PH_START: begin
                if (w_last) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                end
            end
            default: begin
                // idle: nothing runs, counters stay at rest
                n_phase = PH_IDLE;
                n_tick  = w_tick;
            end
        endcase
    end

    // Outputs of this tick
    always_comb begin
        w_rej   = i_head.item.cmd && (r_phase != PH_IDLE);
        w_busy  = w_start || (w_phase != PH_IDLE);
        w_done  = w_busy && (n_phase == PH_IDLE);
        case (w_phase)
            PH_RLOW, PH_RPULSE:                  w_drive = 1'b1;
            PH_WBITS, PH_WACK, PH_RBITS, PH_RACK: w_drive = (w_tick < w_low);
            default:                             w_drive = 1'b0;
        endcase
    end

    // State update, one tick per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_nack     <= 1'b0;
            r_wait     <= '0;
            r_ack      <= 1'b0;
            r_presence <= 1'b0;
            r_held     <= '0;
        end else if (w_fire) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_nack     <= n_nack;
            r_wait     <= n_wait;
            r_ack      <= n_ack;
            r_presence <= n_presence;
            r_held     <= n_held;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {2'b00, w_rej, n_presence, n_ack, n_held,
                           w_done, w_busy, w_drive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/single_wire_eeprom_bus_master.sv
// Master for a single-wire open-drain bus. Every input transfer is one bus
// tick: tuser carries the command kind (none, reset/discovery, write byte,
// read byte, start/stop) and tdata the byte to send, the NACK choice for a
// read and the sampled line level; each tick returns exactly one output
// transfer with the drive-low request, busy/done/rejected status and the
// last read byte, device ACK and presence. A command is taken only in idle
// and starts on the tick that carries it. One tick is accepted every clock
// while the two-entry queue has room; the engine advances the bus state by
// one tick per cycle into an output register while it is empty or drained.
// Timing registers are 10-bit tick counts; the user must write them through
// the plain configuration port while idle, which the block does not enforce.
module single_wire_eeprom_bus_master
    import swbm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [TIMER_BITS-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: data_byte[7:0], master_nack[8], line_level[9], zero pad[15:10]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: drive_low[0], busy_res[1], done_res[2], read_data[10:3],
    //        device_ack[11], presence[12], rejected[13], zero pad[15:14]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_head w_head;
    logic  w_pop;

    swbm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    swbm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import swbm_pkg::*;

    // How the sampled line level is chosen for each tick of a command
    localparam int LINE_RANDOM = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_LOW    = 2;
    localparam int LINE_ANSWER = 3;  // high, but pulled low in the presence window

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    // One result transfer, last field in the lowest bit
    typedef struct packed {
        logic       rejected;
        logic       presence;
        logic       device_ack;
        logic [7:0] read_data;
        logic       done;
        logic       busy;
        logic       drive_low;
    } t_bus_status;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [TIMER_BITS-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: data_byte[7:0], master_nack[8], line_level[9], zero pad[15:10]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: kind[2:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: drive_low[0], busy_res[1], done_res[2], read_data[10:3],
    //        device_ack[11], presence[12], rejected[13], zero pad[15:14]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Expected status of every accepted tick, oldest first
    t_bus_status status_due[$];
    int          mismatch_count = 0;
    int          ticks_sent = 0;
    int          stall_cycles = 0;
    bit          no_gaps = 1'b0;
    bit          hold_req = 1'b0;

    // Bus master state as predicted
    t_tick      timing [8];
    t_phase     bus_phase = PH_IDLE;
    logic [2:0] active_kind = KIND_NONE;
    int         slot_tick = 0;
    int         bit_idx = 0;
    logic [7:0] shift_reg = '0;
    logic       nack_after = 1'b0;
    logic [7:0] wait_left = '0;
    logic       ack_seen = 1'b0;
    logic       presence_seen = 1'b0;
    logic [7:0] last_read = '0;
    logic       cmd_done = 1'b0;

    single_wire_eeprom_bus_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Zero-length times count as one tick
    function automatic int at_least_one(input t_tick v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Count one tick of a phase; true on its last tick
    function automatic bit slot_end(input t_tick len);
        if (slot_tick + 1 >= at_least_one(len)) begin
            slot_tick = 0;
            return 1'b1;
        end
        slot_tick = slot_tick + 1;
        return 1'b0;
    endfunction

    function automatic void enter(input t_phase p);
        bus_phase = p;
        slot_tick = 0;
    endfunction

    function automatic void complete();
        bus_phase   = PH_IDLE;
        active_kind = KIND_NONE;
        slot_tick   = 0;
        bit_idx     = 0;
        cmd_done    = 1'b1;
    endfunction

    // Sample point of a read or ack slot, clipped to the slot's last tick
    function automatic int sample_point();
        int s;
        int last;
        s    = at_least_one(timing[CFG_RD_LOW]) + at_least_one(timing[CFG_RD_SAMPLE]) - 1;
        last = at_least_one(timing[CFG_RD_BIT]) - 1;
        return (s > last) ? last : s;
    endfunction

    // Advance the predicted bus master by one tick
    task automatic step_bus_tick(input logic [2:0] kind, input logic [7:0] data,
                                 input logic nack, input logic line,
                                 output t_bus_status res);
        logic is_cmd;
        int   t;
        res      = '0;
        cmd_done = 1'b0;
        is_cmd   = (kind >= KIND_RESET) && (kind <= KIND_START);

        // command acceptance
        if (bus_phase != PH_IDLE) begin
            if (is_cmd) res.rejected = 1'b1;
        end else if (is_cmd) begin
            slot_tick   = 0;
            bit_idx     = 0;
            active_kind = kind;
            res.busy    = 1'b1;
            case (kind)
                KIND_RESET: begin
                    wait_left = WAIT_INIT;
                    if (wait_left == 8'd0) begin
                        presence_seen = 1'b0;
                        complete();
                    end else begin
                        enter(PH_RWAIT);
                    end
                end
                KIND_WRITE: begin
                    shift_reg = data;
                    enter(PH_WBITS);
                end
                KIND_READ: begin
                    shift_reg  = '0;
                    nack_after = nack;
                    enter(PH_RBITS);
                end
                default: enter(PH_START);
            endcase
        end

        // one tick of the running command
        if (bus_phase != PH_IDLE) begin
            res.busy = 1'b1;
            t = slot_tick;
            case (bus_phase)
                PH_RWAIT: begin
                    if (slot_end(LEN_RWAIT)) begin
                        if (line) begin
                            enter(PH_RHIGH);
                        end else begin
                            wait_left = wait_left - 8'd1;
                            if (wait_left == 8'd0) begin
                                presence_seen = 1'b0;
                                complete();
                            end
                        end
                    end
                end
                PH_RHIGH: if (slot_end(LEN_RHIGH)) enter(PH_RLOW);
                PH_RLOW: begin
                    res.drive_low = 1'b1;
                    if (slot_end(timing[CFG_RST_LOW])) enter(PH_RFLOAT);
                end
                PH_RFLOAT: if (slot_end(LEN_RFLOAT)) enter(PH_RPULSE);
                PH_RPULSE: begin
                    res.drive_low = 1'b1;
                    if (slot_end(LEN_RPULSE)) enter(PH_RSAMPLE);
                end
                PH_RSAMPLE: begin
                    if (slot_end(LEN_RSAMPLE)) begin
                        presence_seen = ~line;
                        enter(PH_RTAIL);
                    end
                end
                PH_RTAIL: if (slot_end(LEN_RTAIL)) complete();
                PH_WBITS: begin
                    res.drive_low = t < at_least_one(shift_reg[7] ? timing[CFG_LOW_ONE]
                                                                  : timing[CFG_LOW_ZERO]);
                    if (slot_end(timing[CFG_WR_BIT])) begin
                        shift_reg = shift_reg << 1;
                        bit_idx   = bit_idx + 1;
                        if (bit_idx >= 8) begin
                            bit_idx = 0;
                            enter(PH_WACK);
                        end
                    end
                end
                PH_WACK: begin
                    res.drive_low = t < at_least_one(timing[CFG_RD_LOW]);
                    if (t == sample_point()) ack_seen = ~line;
                    if (slot_end(timing[CFG_RD_BIT])) complete();
                end
                PH_RBITS: begin
                    res.drive_low = t < at_least_one(timing[CFG_RD_LOW]);
                    if (t == sample_point()) shift_reg = {shift_reg[6:0], line};
                    if (slot_end(timing[CFG_RD_BIT])) begin
                        bit_idx = bit_idx + 1;
                        if (bit_idx >= 8) begin
                            bit_idx   = 0;
                            last_read = shift_reg;
                            enter(PH_RACK);
                        end
                    end
                end
                PH_RACK: begin
                    res.drive_low = t < at_least_one(nack_after ? timing[CFG_LOW_ONE]
                                                                : timing[CFG_LOW_ZERO]);
                    if (slot_end(timing[CFG_WR_BIT])) complete();
                end
                PH_START: if (slot_end(timing[CFG_START_HIGH])) complete();
                default: complete();
            endcase
        end

        res.done       = cmd_done;
        res.read_data  = last_read;
        res.device_ack = ack_seen;
        res.presence   = presence_seen;
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_bus_status want;
        t_bus_status got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_bus_status'(m_axis_tdata[$bits(t_bus_status)-1:0]);
            if (status_due.size() == 0) begin
                $error("status transfer with no tick pending: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = status_due.pop_front();
                check_field("drive_low", want.drive_low, got.drive_low);
                check_field("busy_res", want.busy, got.busy);
                check_field("done_res", want.done, got.done);
                check_field("read_data", want.read_data, got.read_data);
                check_field("device_ack", want.device_ack, got.device_ack);
                check_field("presence", want.presence, got.presence);
                check_field("rejected", want.rejected, got.rejected);
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Status receiver: random stalls, plus a long hold-off on request
    initial begin : status_receiver
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (no_gaps) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic logic pick_line(input int mode);
        case (mode)
            LINE_HIGH:   return 1'b1;
            LINE_LOW:    return 1'b0;
            LINE_ANSWER: return bus_phase != PH_RSAMPLE;
            default:     return 1'($urandom);
        endcase
    endfunction

    // Offer one tick, wait for its transfer, record its expected status
    task automatic send_tick(input logic [2:0] kind, input logic [7:0] data,
                             input logic nack, input logic line);
        t_bus_status res;
        while (!no_gaps && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_TDATA_W'({line, nack, data});
        do @(posedge i_clk); while (!s_axis_tready);
        step_bus_tick(kind, data, nack, line, res);
        status_due.push_back(res);
        ticks_sent++;
    endtask

    // Issue a command and keep ticking until it completes; other kinds may
    // be thrown in while it runs
    task automatic run_command(input logic [2:0] kind, input logic [7:0] data,
                               input logic nack, input int line_mode,
                               input int intrude_pct);
        logic [2:0] k;
        send_tick(kind, data, nack, pick_line(line_mode));
        while (bus_phase != PH_IDLE) begin
            k = KIND_NONE;
            if ($urandom_range(99) < intrude_pct) k = 3'($urandom_range(7));
            send_tick(k, 8'($urandom), 1'($urandom), pick_line(line_mode));
        end
    endtask

    // Stop sending and wait for every pending status
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= t_tick'(value);
        @(posedge i_clk);
        timing[idx] = t_tick'(value);
    endtask

    task automatic set_timings(input int low_one, input int low_zero, input int wr_bit,
                               input int rd_low, input int rd_sample, input int rd_bit,
                               input int rst_low, input int start_high);
        settle_idle();
        write_reg(CFG_LOW_ONE, low_one);
        write_reg(CFG_LOW_ZERO, low_zero);
        write_reg(CFG_WR_BIT, wr_bit);
        write_reg(CFG_RD_LOW, rd_low);
        write_reg(CFG_RD_SAMPLE, rd_sample);
        write_reg(CFG_RD_BIT, rd_bit);
        write_reg(CFG_RST_LOW, rst_low);
        write_reg(CFG_START_HIGH, start_high);
        i_cfg_we <= 1'b0;
    endtask

    // Reset values of the timing registers
    task automatic test_default_timing();
        run_command(KIND_WRITE, 8'hC3, 1'b0, LINE_RANDOM, 0);
    endtask

    // Byte extremes, ack and nack, start/stop, ignored kinds, busy rejects
    task automatic test_byte_transfers();
        set_timings(1, 2, 3, 1, 1, 3, 2, 1);
        run_command(KIND_WRITE, 8'h00, 1'b0, LINE_LOW, 0);
        run_command(KIND_READ, 8'hFF, 1'b0, LINE_HIGH, 0);
        run_command(KIND_READ, 8'h00, 1'b1, LINE_LOW, 0);
        run_command(KIND_START, 8'h00, 1'b0, LINE_RANDOM, 0);
        // kinds above start/stop are ignored in idle
        for (int k = 5; k < 8; k++) send_tick(3'(k), 8'($urandom), 1'($urandom), 1'b1);
        // every later tick of this command carries a random kind
        run_command(KIND_WRITE, 8'h3C, 1'b0, LINE_HIGH, 100);
    endtask

    // All times zero: every phase shrinks to one tick
    task automatic test_zero_timings();
        set_timings(0, 0, 0, 0, 0, 0, 0, 0);
        run_command(KIND_WRITE, 8'h96, 1'b0, LINE_RANDOM, 0);
        run_command(KIND_READ, 8'h00, 1'b1, LINE_RANDOM, 0);
        run_command(KIND_READ, 8'h00, 1'b0, LINE_RANDOM, 0);
        run_command(KIND_START, 8'h00, 1'b0, LINE_RANDOM, 0);
    endtask

    // Device answering with no idling on either side, then a line stuck low;
    // runs with the reset low time still at zero
    task automatic test_bus_reset();
        no_gaps = 1'b1;
        run_command(KIND_RESET, 8'h00, 1'b0, LINE_ANSWER, 10);
        no_gaps = 1'b0;
        run_command(KIND_RESET, 8'h00, 1'b0, LINE_LOW, 0);
    endtask

    // Low pulses longer than the slot, sample point past the slot end
    task automatic test_long_pulses();
        set_timings(7, 12, 5, 2, 9, 5, 3, 4);
        run_command(KIND_WRITE, 8'h81, 1'b0, LINE_RANDOM, 0);
        run_command(KIND_READ, 8'h00, 1'b1, LINE_RANDOM, 0);
    endtask

    // Largest low times and sample delay against short slots
    task automatic test_max_timings();
        set_timings(1023, 1023, 3, 1023, 1023, 3, 1023, 1023);
        run_command(KIND_WRITE, 8'h69, 1'b0, LINE_RANDOM, 5);
        run_command(KIND_READ, 8'h00, 1'b0, LINE_RANDOM, 5);
    endtask

    task automatic random_command();
        int pick;
        int line_mode;
        pick = $urandom_range(99);
        if (pick < 35) begin
            run_command(KIND_WRITE, 8'($urandom), 1'($urandom), LINE_RANDOM, 4);
        end else if (pick < 68) begin
            run_command(KIND_READ, 8'($urandom), 1'($urandom), LINE_RANDOM, 4);
        end else if (pick < 80) begin
            run_command(KIND_START, 8'($urandom), 1'($urandom), LINE_RANDOM, 4);
        end else if (pick < 88) begin
            line_mode = ($urandom_range(1) == 1) ? LINE_ANSWER : LINE_RANDOM;
            run_command(KIND_RESET, 8'($urandom), 1'($urandom), line_mode, 4);
        end else begin
            // noise: no command, or a kind the block ignores
            repeat ($urandom_range(4, 1))
                send_tick(($urandom_range(1) == 1) ? KIND_NONE : 3'($urandom_range(7, 5)),
                          8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // Random command streams over several random small timing sets
    task automatic test_random_traffic();
        int target;
        for (int round = 0; round < 3; round++) begin
            set_timings($urandom_range(4, 1), $urandom_range(8, 1), $urandom_range(10, 2),
                        $urandom_range(3, 1), $urandom_range(4, 1), $urandom_range(8, 3),
                        $urandom_range(40, 1), $urandom_range(30, 1));
            // long receiver hold-off while ticks keep coming
            if (round == 1) hold_req = 1'b1;
            target = ticks_sent + 25;
            while (ticks_sent < target) random_command();
        end
    endtask

    initial begin
        timing[CFG_LOW_ONE]    = t_tick'(1);
        timing[CFG_LOW_ZERO]   = t_tick'(10);
        timing[CFG_WR_BIT]     = t_tick'(15);
        timing[CFG_RD_LOW]     = t_tick'(1);
        timing[CFG_RD_SAMPLE]  = t_tick'(1);
        timing[CFG_RD_BIT]     = t_tick'(11);
        timing[CFG_RST_LOW]    = t_tick'(480);
        timing[CFG_START_HIGH] = t_tick'(150);
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_NONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_byte_transfers();
        test_zero_timings();
        test_bus_reset();
        test_long_pulses();
        test_max_timings();
        test_random_traffic();

        settle_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> single_wire_eeprom_bus_master.f
rtl/swbm_pkg.sv
rtl/swbm_front.sv
rtl/swbm_engine.sv
rtl/single_wire_eeprom_bus_master.sv
sim/testbench.sv
